### src/assert_macros.svh
// Assertion macros used by the top-level RTL file; clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/idbm_pkg.sv
// Types and constants of the icon directory best-match selector.
`default_nettype none

package idbm_pkg;

    localparam int SIZE_W  = 12;
    localparam int SCALE_W = 4;
    localparam int PROD_W  = SIZE_W + SCALE_W;
    localparam int DIST_W  = 18;
    localparam int IDX_W   = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_REQ_WIDTH  = 2'd0;
    localparam logic [1:0] REG_REQ_HEIGHT = 2'd1;
    localparam logic [1:0] REG_REQ_SCALE  = 2'd2;

    localparam logic [SIZE_W-1:0]  REQ_WIDTH_RST  = 12'd32;
    localparam logic [SIZE_W-1:0]  REQ_HEIGHT_RST = 12'd32;
    localparam logic [SCALE_W-1:0] REQ_SCALE_RST  = 4'd1;

    typedef enum logic [1:0] {
        KIND_FIXED    = 2'd0,
        KIND_SCALABLE = 2'd1,
        KIND_THRESH   = 2'd2,
        KIND_OTHER    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  side;
        logic [SCALE_W-1:0] scale;
    } cfg_t;

    // Classified descriptor handed from the front end to the selector.
    typedef struct packed {
        logic                     sel;
        logic                     match;
        logic signed [DIST_W-1:0] distance;
        logic                     last;
    } cls_t;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             found;
        logic             exact;
    } res_t;

endpackage

`default_nettype wire

### src/idbm_queue.sv
// Small register-based FIFO used between the pipeline parts.
`default_nettype none

module idbm_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wr_data,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

### src/idbm_front.sv
// Front end: takes descriptors, checks the exact rule and computes the size distance.
`default_nettype none

module idbm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  idbm_pkg::cfg_t      cfg,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          dir_kind,
    input  logic [11:0]         nom_size,
    input  logic [11:0]         dir_min,
    input  logic [11:0]         dir_max,
    input  logic [11:0]         dir_thresh,
    input  logic [3:0]          dir_scale,
    input  logic                last_entry,
    output logic                q_push,
    input  logic                q_full,
    output idbm_pkg::cls_t      q_data
);

    import idbm_pkg::*;

    // stage 1: captured descriptor
    logic               s1_valid_reg;
    kind_t              s1_kind_reg;
    logic [SIZE_W-1:0]  s1_size_reg, s1_min_reg, s1_max_reg, s1_thr_reg;
    logic [SCALE_W-1:0] s1_scale_reg;
    logic               s1_last_reg;

    // stage 2: products and match flag
    logic                     s2_valid_reg;
    kind_t                    s2_kind_reg;
    logic                     s2_match_reg;
    logic                     s2_last_reg;
    logic [PROD_W-1:0]        s2_psize_reg, s2_pmin_reg, s2_pmax_reg, s2_bigs_reg;
    logic signed [DIST_W-1:0] s2_plo_reg;
    logic [PROD_W:0]          s2_phi_reg;

    logic                     s1_adv, s2_adv, accept;
    logic                     match;
    logic signed [SIZE_W:0]   lo;
    logic [SIZE_W:0]          hi;
    logic [PROD_W-1:0]        psize, pmin, pmax, bigs;
    logic signed [DIST_W-1:0] plo;
    logic [PROD_W:0]          phi;

    logic signed [DIST_W-1:0] e_size, e_min, e_max, e_bigs, e_hi, diff, distance;

    assign s2_adv = !s2_valid_reg || !q_full;
    assign s1_adv = !s1_valid_reg || s2_adv;
    assign full   = !s1_adv;
    assign accept = push && !full;
    assign q_push = s2_valid_reg && !q_full;

    always_comb
    begin
        lo    = $signed({1'b0, s1_size_reg}) - $signed({1'b0, s1_thr_reg});
        hi    = {1'b0, s1_size_reg} + {1'b0, s1_thr_reg};
        match = 1'b0;
        if (s1_scale_reg == cfg.scale)
        begin
            unique case (s1_kind_reg)
                KIND_FIXED:    match = (s1_size_reg == cfg.side);
                KIND_SCALABLE: match = (cfg.side <= s1_max_reg) && (cfg.side >= s1_min_reg);
                KIND_THRESH:   match = ($signed({1'b0, cfg.side}) >= lo)
                                       && ({1'b0, cfg.side} <= hi);
                KIND_OTHER:    match = 1'b0;
            endcase
        end
        psize = PROD_W'(s1_size_reg) * PROD_W'(s1_scale_reg);
        pmin  = PROD_W'(s1_min_reg) * PROD_W'(s1_scale_reg);
        pmax  = PROD_W'(s1_max_reg) * PROD_W'(s1_scale_reg);
        bigs  = PROD_W'(cfg.side) * PROD_W'(cfg.scale);
        plo   = DIST_W'(lo) * DIST_W'($signed({1'b0, s1_scale_reg}));
        phi   = (PROD_W + 1)'(hi) * (PROD_W + 1)'(s1_scale_reg);
    end

    always_comb
    begin
        e_size   = $signed(DIST_W'(s2_psize_reg));
        e_min    = $signed(DIST_W'(s2_pmin_reg));
        e_max    = $signed(DIST_W'(s2_pmax_reg));
        e_bigs   = $signed(DIST_W'(s2_bigs_reg));
        e_hi     = $signed(DIST_W'(s2_phi_reg));
        diff     = e_size - e_bigs;
        distance = '0;
        unique case (s2_kind_reg)
            KIND_FIXED:
            begin
                distance = diff[DIST_W-1] ? -diff : diff;
            end
            KIND_SCALABLE:
            begin
                if (e_bigs < e_min)
                    distance = e_min - e_bigs;
                else if (e_bigs > e_max)
                    distance = e_bigs - e_max;
            end
            KIND_THRESH:
            begin
                // bounds come from size +/- thresh, the distance from min/max
                if (e_bigs < s2_plo_reg)
                    distance = e_min - e_bigs;
                else if (e_bigs > e_hi)
                    distance = e_bigs - e_max;
            end
            KIND_OTHER:
            begin
                distance = '0;
            end
        endcase
        q_data.sel      = (s2_kind_reg != KIND_OTHER);
        q_data.match    = s2_match_reg;
        q_data.distance = distance;
        q_data.last     = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= accept;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= kind_t'(dir_kind);
            s1_size_reg  <= nom_size;
            s1_min_reg   <= dir_min;
            s1_max_reg   <= dir_max;
            s1_thr_reg   <= dir_thresh;
            s1_scale_reg <= dir_scale;
            s1_last_reg  <= last_entry;
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_match_reg <= match;
            s2_last_reg  <= s1_last_reg;
            s2_psize_reg <= psize;
            s2_pmin_reg  <= pmin;
            s2_pmax_reg  <= pmax;
            s2_bigs_reg  <= bigs;
            s2_plo_reg   <= plo;
            s2_phi_reg   <= phi;
        end
    end

endmodule

`default_nettype wire

### src/idbm_back.sv
// Back end: tracks first exact match and first smallest distance, emits one result per set.
`default_nettype none

module idbm_back #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  idbm_pkg::cls_t q_data,
    output logic           q_pop,
    input  logic           r_full,
    output logic           r_push,
    output idbm_pkg::res_t r_data
);

    import idbm_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (CW < IDX_W) ? CW : IDX_W;

    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     exact_seen_reg, exact_seen_next;
    logic [IW-1:0]            exact_idx_reg, exact_idx_next;
    logic                     best_seen_reg, best_seen_next;
    logic signed [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [IW-1:0]            best_idx_reg, best_idx_next;

    logic go, in_range, take;

    assign go       = !q_empty && !r_full;
    assign q_pop    = go;
    assign in_range = (cnt_reg < CW'(MAX_ENTRIES));
    assign take     = in_range && q_data.sel;
    assign r_push   = go && q_data.last;

    always_comb
    begin
        cnt_next        = cnt_reg;
        exact_seen_next = exact_seen_reg;
        exact_idx_next  = exact_idx_reg;
        best_seen_next  = best_seen_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        if (go)
        begin
            if (take && q_data.match && !exact_seen_reg)
            begin
                exact_seen_next = 1'b1;
                exact_idx_next  = cnt_reg[IW-1:0];
            end
            if (take && (!best_seen_reg || (q_data.distance < best_dist_reg)))
            begin
                best_seen_next = 1'b1;
                best_dist_next = q_data.distance;
                best_idx_next  = cnt_reg[IW-1:0];
            end
            if (in_range)
                cnt_next = cnt_reg + 1'b1;
        end

        if (exact_seen_next)
        begin
            r_data.index = IDX_W'(exact_idx_next);
            r_data.found = 1'b1;
            r_data.exact = 1'b1;
        end
        else if (best_seen_next)
        begin
            r_data.index = IDX_W'(best_idx_next);
            r_data.found = 1'b1;
            r_data.exact = 1'b0;
        end
        else
        begin
            r_data.index = '0;
            r_data.found = 1'b0;
            r_data.exact = 1'b0;
        end

        // end of set: start over
        if (r_push)
        begin
            cnt_next        = '0;
            exact_seen_next = 1'b0;
            exact_idx_next  = '0;
            best_seen_next  = 1'b0;
            best_dist_next  = '0;
            best_idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            exact_seen_reg <= 1'b0;
            exact_idx_reg  <= '0;
            best_seen_reg  <= 1'b0;
            best_dist_reg  <= '0;
            best_idx_reg   <= '0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            exact_seen_reg <= exact_seen_next;
            exact_idx_reg  <= exact_idx_next;
            best_seen_reg  <= best_seen_next;
            best_dist_reg  <= best_dist_next;
            best_idx_reg   <= best_idx_next;
        end
    end

endmodule

`default_nettype wire

### src/icon_directory_best_match.sv
// Top level of the icon directory best-match selector.
`default_nettype none
`include "assert_macros.svh"

// Picks one icon directory out of a set of descriptors for the requested size
// min(req_width, req_height) at req_scale. Descriptors are pushed one per cycle
// while full is low, without bubbles; the set ends on the descriptor with
// last_entry set, and that one produces a single result (first exact match, else
// first smallest distance, else found = 0). A descriptor goes through two
// front-end stages (capture, then multiply and compare), a 4-deep queue, the
// selector and a 2-deep result queue. Throughput is one descriptor per cycle
// while full is low. Positions at or beyond MAX_ENTRIES are not considered; the
// position counter stops there. Registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this.
module icon_directory_best_match #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [idbm_pkg::ADDR_W-1:0] paddr,
    input  logic [idbm_pkg::DATA_W-1:0] pwdata,
    output logic [idbm_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  dir_kind,
    input  logic [11:0]                 nom_size,
    input  logic [11:0]                 dir_min,
    input  logic [11:0]                 dir_max,
    input  logic [11:0]                 dir_thresh,
    input  logic [3:0]                  dir_scale,
    input  logic                        last_entry,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  chosen_index,
    output logic                        found,
    output logic                        exact
);

    import idbm_pkg::*;

    logic [SIZE_W-1:0]  req_width_reg;
    logic [SIZE_W-1:0]  req_height_reg;
    logic [SCALE_W-1:0] req_scale_reg;
    logic               wr_en;
    logic [1:0]         reg_sel;
    cfg_t               cfg;

    logic mid_push, mid_full, mid_pop, mid_empty;
    cls_t mid_wr, mid_rd;
    logic res_push, res_full;
    res_t res_wr, res_rd;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_comb
    begin
        unique case (reg_sel)
            REG_REQ_WIDTH:  prdata = DATA_W'(req_width_reg);
            REG_REQ_HEIGHT: prdata = DATA_W'(req_height_reg);
            REG_REQ_SCALE:  prdata = DATA_W'(req_scale_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_width_reg  <= REQ_WIDTH_RST;
            req_height_reg <= REQ_HEIGHT_RST;
            req_scale_reg  <= REQ_SCALE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_REQ_WIDTH:  req_width_reg  <= pwdata[SIZE_W-1:0];
                REG_REQ_HEIGHT: req_height_reg <= pwdata[SIZE_W-1:0];
                REG_REQ_SCALE:  req_scale_reg  <= pwdata[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg.side  = (req_width_reg < req_height_reg) ? req_width_reg : req_height_reg;
    assign cfg.scale = req_scale_reg;

    idbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .push       (push),
        .full       (full),
        .dir_kind   (dir_kind),
        .nom_size   (nom_size),
        .dir_min    (dir_min),
        .dir_max    (dir_max),
        .dir_thresh (dir_thresh),
        .dir_scale  (dir_scale),
        .last_entry (last_entry),
        .q_push     (mid_push),
        .q_full     (mid_full),
        .q_data     (mid_wr)
    );

    idbm_queue #(
        .W     ($bits(cls_t)),
        .DEPTH (4)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .full    (mid_full),
        .wr_data (mid_wr),
        .pop     (mid_pop),
        .empty   (mid_empty),
        .rd_data (mid_rd)
    );

    idbm_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (mid_empty),
        .q_data  (mid_rd),
        .q_pop   (mid_pop),
        .r_full  (res_full),
        .r_push  (res_push),
        .r_data  (res_wr)
    );

    idbm_queue #(
        .W     ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .full    (res_full),
        .wr_data (res_wr),
        .pop     (pop),
        .empty   (empty),
        .rd_data (res_rd)
    );

    assign chosen_index = res_rd.index;
    assign found        = res_rd.found;
    assign exact        = res_rd.exact;

    `AST_IMP(a_not_found, !empty && !found, !exact && (chosen_index == 8'd0))
    `AST_IMP(a_exact_found, !empty && exact, found)
    `AST_NEXT(a_result_visible, res_push, !empty)

endmodule

`default_nettype wire

### bench/best_match_checker.sv
// Checker for the icon directory best-match selector: tracks registers, predicts picks, compares.
`timescale 1ns / 100ps

module best_match_checker
    import idbm_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    input  logic              push,
    input  logic              full,
    input  logic [1:0]        dir_kind,
    input  logic [11:0]       nom_size,
    input  logic [11:0]       dir_min,
    input  logic [11:0]       dir_max,
    input  logic [11:0]       dir_thresh,
    input  logic [3:0]        dir_scale,
    input  logic              last_entry,
    input  logic              empty,
    input  logic              pop,
    input  logic [7:0]        chosen_index,
    input  logic              found,
    input  logic              exact,
    output int                mismatches,
    output int                pending
);

    logic [SIZE_W-1:0]  want_width;
    logic [SIZE_W-1:0]  want_height;
    logic [SCALE_W-1:0] want_scale;

    int               set_pos;
    logic             exact_hit;
    logic [IDX_W-1:0] exact_pos;
    logic             dist_hit;
    int               closest;
    logic [IDX_W-1:0] closest_pos;

    res_t expected_picks[$];

    initial mismatches = 0;

    task automatic flag(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        int   side;
        int   big;
        int   sz;
        int   mn;
        int   mx;
        int   th;
        int   sc;
        int   gap;
        logic hit;
        res_t pick;

        if (!rst_n) begin
            want_width  = REQ_WIDTH_RST;
            want_height = REQ_HEIGHT_RST;
            want_scale  = REQ_SCALE_RST;
            set_pos     = 0;
            exact_hit   = 1'b0;
            exact_pos   = '0;
            dist_hit    = 1'b0;
            closest     = 0;
            closest_pos = '0;
            expected_picks.delete();
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_REQ_WIDTH:  want_width  = pwdata[SIZE_W-1:0];
                    REG_REQ_HEIGHT: want_height = pwdata[SIZE_W-1:0];
                    REG_REQ_SCALE:  want_scale  = pwdata[SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (push && !full) begin
                side = int'((want_width < want_height) ? want_width : want_height);
                big  = side * int'(want_scale);
                sz   = int'(nom_size);
                mn   = int'(dir_min);
                mx   = int'(dir_max);
                th   = int'(dir_thresh);
                sc   = int'(dir_scale);
                // positions past the window are never considered; set_pos stops at the window end
                if (set_pos < MAX_ENTRIES && kind_t'(dir_kind) != KIND_OTHER) begin
                    hit = 1'b0;
                    gap = 0;
                    if (dir_scale == want_scale) begin
                        case (kind_t'(dir_kind))
                            KIND_FIXED:    hit = (sz == side);
                            KIND_SCALABLE: hit = (side >= mn && side <= mx);
                            default:       hit = (side >= sz - th && side <= sz + th);
                        endcase
                    end
                    case (kind_t'(dir_kind))
                        KIND_FIXED: begin
                            gap = sz * sc - big;
                            if (gap < 0)
                                gap = -gap;
                        end
                        KIND_SCALABLE: begin
                            if (big < mn * sc)
                                gap = mn * sc - big;
                            else if (big > mx * sc)
                                gap = big - mx * sc;
                        end
                        default: begin
                            // bounds test uses size +/- thresh, distance uses min/max
                            if (big < (sz - th) * sc)
                                gap = mn * sc - big;
                            else if (big > (sz + th) * sc)
                                gap = big - mx * sc;
                        end
                    endcase
                    if (hit && !exact_hit) begin
                        exact_hit = 1'b1;
                        exact_pos = set_pos[IDX_W-1:0];
                    end
                    if (!dist_hit || gap < closest) begin
                        dist_hit    = 1'b1;
                        closest     = gap;
                        closest_pos = set_pos[IDX_W-1:0];
                    end
                end
                if (set_pos < MAX_ENTRIES)
                    set_pos++;

                if (last_entry) begin
                    if (exact_hit)
                        pick = '{index: exact_pos, found: 1'b1, exact: 1'b1};
                    else if (dist_hit)
                        pick = '{index: closest_pos, found: 1'b1, exact: 1'b0};
                    else
                        pick = '{index: '0, found: 1'b0, exact: 1'b0};
                    expected_picks.insert(expected_picks.size(), pick);
                    set_pos     = 0;
                    exact_hit   = 1'b0;
                    exact_pos   = '0;
                    dist_hit    = 1'b0;
                    closest     = 0;
                    closest_pos = '0;
                end
            end

            if (pop && !empty) begin
                if (expected_picks.size() == 0) begin
                    flag($sformatf("result transfer with none expected (index %0d)",
                                   chosen_index));
                end else begin
                    pick = expected_picks.pop_front();
                    if (chosen_index !== pick.index)
                        flag($sformatf("chosen_index %0d, expected %0d",
                                       chosen_index, pick.index));
                    if (found !== pick.found)
                        flag($sformatf("found %b, expected %b", found, pick.found));
                    if (exact !== pick.exact)
                        flag($sformatf("exact %b, expected %b", exact, pick.exact));
                end
            end

            pending <= expected_picks.size();
        end
    end

endmodule

### bench/icon_directory_best_match_tb.sv
// Testbench top for the icon directory best-match selector: stimulus, reset and verdict.
`timescale 1ns / 100ps

module icon_directory_best_match_tb;

    import idbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 10;
    localparam int PHASE_ITEMS = 260;
    localparam int PHASES      = 7;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              push       = 1'b0;
    logic              full;
    logic [1:0]        dir_kind   = KIND_FIXED;
    logic [11:0]       nom_size   = '0;
    logic [11:0]       dir_min    = '0;
    logic [11:0]       dir_max    = '0;
    logic [11:0]       dir_thresh = '0;
    logic [3:0]        dir_scale  = 4'd1;
    logic              last_entry = 1'b0;
    logic              empty;
    logic              pop        = 1'b0;
    logic [7:0]        chosen_index;
    logic              found;
    logic              exact;

    int mismatches;
    int pending;
    int cycles = 0;

    // stimulus side copy of the request, written over APB and used to aim descriptors near it
    logic [SIZE_W-1:0]  cur_width  = REQ_WIDTH_RST;
    logic [SIZE_W-1:0]  cur_height = REQ_HEIGHT_RST;
    logic [SCALE_W-1:0] cur_scale  = REQ_SCALE_RST;

    logic calm     = 1'b0;
    logic hold_req = 1'b0;

    icon_directory_best_match dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full),
        .dir_kind(dir_kind), .nom_size(nom_size), .dir_min(dir_min),
        .dir_max(dir_max), .dir_thresh(dir_thresh), .dir_scale(dir_scale),
        .last_entry(last_entry),
        .empty(empty), .pop(pop),
        .chosen_index(chosen_index), .found(found), .exact(exact)
    );

    best_match_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .push(push), .full(full),
        .dir_kind(dir_kind), .nom_size(nom_size), .dir_min(dir_min),
        .dir_max(dir_max), .dir_thresh(dir_thresh), .dir_scale(dir_scale),
        .last_entry(last_entry),
        .empty(empty), .pop(pop),
        .chosen_index(chosen_index), .found(found), .exact(exact),
        .mismatches(mismatches), .pending(pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off on request
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    function automatic logic [11:0] clip(input int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return v[11:0];
    endfunction

    task automatic apb_write(input logic [1:0] reg_sel, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_request(input int w, input int h, input int sc);
        cur_width  = w[SIZE_W-1:0];
        cur_height = h[SIZE_W-1:0];
        cur_scale  = sc[SCALE_W-1:0];
        apb_write(REG_REQ_WIDTH, DATA_W'(cur_width));
        apb_write(REG_REQ_HEIGHT, DATA_W'(cur_height));
        apb_write(REG_REQ_SCALE, DATA_W'(cur_scale));
    endtask

    task automatic send_dir(input kind_t kind, input logic [11:0] size,
                            input logic [11:0] lo, input logic [11:0] hi,
                            input logic [11:0] tol, input logic [3:0] scale,
                            input logic lst);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        dir_kind   <= kind;
        nom_size   <= size;
        dir_min    <= lo;
        dir_max    <= hi;
        dir_thresh <= tol;
        dir_scale  <= scale;
        last_entry <= lst;
        do @(posedge clk); while (full);
    endtask

    // wait for every pick to come out, then let the pipeline settle
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_set(input int len);
        int   side;
        int   i;
        logic [11:0] a;
        logic [11:0] b;
        logic [11:0] t;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 60) begin
                // aimed near the requested size so exact matches and ties occur
                side = int'((cur_width < cur_height) ? cur_width : cur_height);
                a = clip(side - int'($urandom_range(0, 6)));
                b = clip(side + int'($urandom_range(0, 6)));
                t = 12'($urandom_range(0, 6));
                if ($urandom_range(0, 9) == 0)
                    {a, b} = {b, a};
                send_dir(kind_t'($urandom_range(0, 3)),
                         clip(side + int'($urandom_range(0, 8)) - 4), a, b, t,
                         ($urandom_range(0, 3) != 0) ? cur_scale : 4'($urandom_range(0, 15)),
                         i == len - 1);
            end else begin
                send_dir(kind_t'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                         12'($urandom), 12'($urandom), 4'($urandom), i == len - 1);
            end
        end
    endtask

    initial begin : stimulus
        int p;
        int count;
        int len;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset request: side 32 at scale 1
        send_dir(KIND_OTHER, 12'd32, 12'd0, 12'd4095, 12'd0, 4'd1, 1'b1);
        send_dir(KIND_FIXED, 12'd0, 12'd0, 12'd0, 12'd0, 4'd0, 1'b0);
        send_dir(KIND_FIXED, 12'd4095, 12'd0, 12'd0, 12'd0, 4'd15, 1'b0);
        send_dir(KIND_SCALABLE, 12'd32, 12'd40, 12'd10, 12'd0, 4'd1, 1'b0);
        send_dir(KIND_THRESH, 12'd100, 12'd4095, 12'd0, 12'd4095, 4'd1, 1'b1);
        // negative threshold distance wins over a positive one
        send_dir(KIND_THRESH, 12'd100, 12'd0, 12'd0, 12'd10, 4'd2, 1'b0);
        send_dir(KIND_FIXED, 12'd32, 12'd0, 12'd0, 12'd0, 4'd3, 1'b1);
        // tie on distance keeps the first
        send_dir(KIND_SCALABLE, 12'd0, 12'd50, 12'd60, 12'd0, 4'd1, 1'b0);
        send_dir(KIND_FIXED, 12'd40, 12'd0, 12'd0, 12'd0, 4'd1, 1'b0);
        send_dir(KIND_FIXED, 12'd24, 12'd0, 12'd0, 12'd0, 4'd1, 1'b0);
        send_dir(KIND_OTHER, 12'd32, 12'd32, 12'd32, 12'd0, 4'd1, 1'b1);
        // first exact match beats a later one and an earlier inexact entry
        send_dir(KIND_FIXED, 12'd32, 12'd0, 12'd0, 12'd0, 4'd2, 1'b0);
        send_dir(KIND_SCALABLE, 12'd0, 12'd0, 12'd4095, 12'd0, 4'd1, 1'b0);
        send_dir(KIND_FIXED, 12'd32, 12'd0, 12'd0, 12'd0, 4'd1, 1'b1);
        send_dir(KIND_OTHER, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'd15, 1'b0);
        send_dir(KIND_THRESH, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'd15, 1'b1);
        send_dir(KIND_FIXED, 12'd32, 12'd0, 12'd0, 12'd0, 4'd1, 1'b1);
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: set_request(4095, 4095, 15);
                1: set_request(0, 0, 0);
                2: set_request(64, 4095, 2);
                3: set_request(4095, 17, 1);
                4: set_request(24, 48, 3);
                default: set_request($urandom_range(0, 4095), $urandom_range(0, 4095),
                                     $urandom_range(0, 15));
            endcase
            calm = (p == 1);
            if (p == 3)
                hold_req = 1'b1;
            count = 0;
            // one set that runs past the selection window
            if (p == 2) begin
                send_set(300);
                count = 300;
            end
            while (count < PHASE_ITEMS) begin
                len = ($urandom_range(0, 199) == 0) ? $urandom_range(257, 300)
                                                    : $urandom_range(1, 10);
                send_set(len);
                count += len;
            end
            calm = 1'b0;
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/idbm_pkg.sv
src/idbm_queue.sv
src/idbm_front.sv
src/idbm_back.sv
src/icon_directory_best_match.sv
bench/best_match_checker.sv
bench/icon_directory_best_match_tb.sv
